@@ rtl/core/tkm_pkg.sv @@
package tkm_pkg;

  localparam int MAX_TUNNELS = 16;
  localparam int IDX_W = $clog2(MAX_TUNNELS);
  localparam int CNT_W = $clog2(MAX_TUNNELS + 1);

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_ACK  = 2'd2;
  localparam logic [1:0] OP_STAT = 2'd3;

  localparam logic [2:0] KIND_ADD   = 3'd0;
  localparam logic [2:0] KIND_SENT  = 3'd1;
  localparam logic [2:0] KIND_ACK   = 3'd2;
  localparam logic [2:0] KIND_STAT  = 3'd3;
  localparam logic [2:0] KIND_IDLE  = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_BADIDX   = 3'd4;

  localparam logic [3:0] REG_INITIAL_LINK_UP = 4'd0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_OUT,
    S_HOLD
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic             load;     // capture the input item
    logic             clr_idx;  // restart the entry pointer
    logic             inc_idx;  // step the entry pointer
    logic             rd;       // read entry at pointer, or at the stat index
    logic             match_chk;// compare key of entry just read
    logic             commit;   // write back to the table
    logic             emit;     // raise output valid
    logic             rel;      // let a held keepalive go out
    logic             fin;      // mark the held keepalive as the last one
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] op;
    logic       idx_end;   // pointer has reached the fill count
    logic       found;     // key match seen
    logic       due;       // entry just read is due
    logic       out_busy;  // result register still full
    logic       any_sent;  // a tick has produced a result
  } stat_t;

endpackage

@@ rtl/core/tkm_ctrl.sv @@
module tkm_ctrl
  import tkm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_fire,
  input  stat_t st,
  output cmd_t  cmd,
  output logic  in_ready
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          cmd.clr_idx = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Search (add, ack) or walk (tick) the table one entry at a time; stat reads its entry directly.
        if (st.op == OP_STAT) begin
          cmd.rd = 1'b1;
          state_nxt = S_OUT;
        end else if (st.idx_end || st.found) begin
          state_nxt = S_OUT;
        end else begin
          cmd.rd = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (st.op == OP_TICK) begin
          if (st.due) begin
            state_nxt = S_HOLD;
          end else begin
            cmd.inc_idx = 1'b1;
            state_nxt = S_SCAN;
          end
        end else begin
          cmd.match_chk = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_HOLD: begin
        // Another keepalive is due, so the held one is not the last: let it go,
        // then send the new one once the result register is free.
        cmd.rel = 1'b1;
        if (!st.out_busy) begin
          cmd.commit = 1'b1;
          cmd.emit = 1'b1;
          cmd.inc_idx = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_OUT: begin
        if (st.op == OP_TICK && st.any_sent) begin
          cmd.rel = 1'b1;
          cmd.fin = 1'b1;
          state_nxt = S_IDLE;
        end else if (!st.out_busy) begin
          cmd.commit = 1'b1;
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/tkm_datapath.sv @@
module tkm_datapath
  import tkm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  cmd_t         cmd,
  output stat_t        st,
  input  logic [91:0]  in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         link_init,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,
  output logic [2:0]   out_tuser,
  output logic         out_tlast
);

  logic [1:0]  op_r;
  logic [31:0] loc_r, rem_r;
  logic [15:0] per_r;
  logic [7:0]  rty_r;
  logic [3:0]  sidx_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] ptr_r;
  logic [31:0] secs_r;
  logic        found_r;
  logic [IDX_W-1:0] fidx_r;
  logic        sent_r;

  logic [31:0] m_loc [MAX_TUNNELS];
  logic [31:0] m_rem [MAX_TUNNELS];
  logic [15:0] m_per [MAX_TUNNELS];
  logic [7:0]  m_rty [MAX_TUNNELS];
  logic [15:0] m_pend [MAX_TUNNELS];
  logic        m_nev [MAX_TUNNELS];
  logic [31:0] m_last [MAX_TUNNELS];
  logic        m_link [MAX_TUNNELS];
  logic [31:0] m_trans [MAX_TUNNELS];

  logic [31:0] rd_loc, rd_rem, rd_last, rd_trans;
  logic [15:0] rd_per, rd_pend;
  logic [7:0]  rd_rty;
  logic        rd_nev, rd_link;

  logic        ov_r, olast_r, hold_r;
  logic [127:0] od_r;
  logic [2:0]  ou_r;

  logic [IDX_W-1:0] ptr_idx;
  logic [IDX_W-1:0] rd_addr;
  assign ptr_idx = ptr_r[IDX_W-1:0];
  assign rd_addr = (op_r == OP_STAT) ? sidx_r[IDX_W-1:0] : ptr_idx;

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_loc <= m_loc[rd_addr];
      rd_rem <= m_rem[rd_addr];
      rd_per <= m_per[rd_addr];
      rd_rty <= m_rty[rd_addr];
      rd_pend <= m_pend[rd_addr];
      rd_nev <= m_nev[rd_addr];
      rd_last <= m_last[rd_addr];
      rd_link <= m_link[rd_addr];
      rd_trans <= m_trans[rd_addr];
    end
  end

  logic [31:0] age;
  logic        due;
  logic        hit;
  assign age = secs_r - rd_last;
  assign due = age >= {16'd0, rd_per};
  assign hit = (rd_loc == loc_r) && (rd_rem == rem_r);

  // Result fields for the entry in the read register.
  logic [15:0] pend_tick;
  logic        down_tick;
  always_comb begin
    if (rd_nev) pend_tick = 16'd1;
    else if (rd_pend != 16'hFFFF) pend_tick = rd_pend + 16'd1;
    else pend_tick = rd_pend;
    down_tick = (pend_tick > {8'd0, rd_rty}) && rd_link;
  end

  logic        full;
  logic        stat_ok;
  assign full = count_r == CNT_W'(MAX_TUNNELS);
  assign stat_ok = {1'b0, sidx_r} < 5'(count_r);

  always_comb begin
    st.op = op_r;
    st.idx_end = ptr_r == count_r;
    st.found = found_r;
    st.due = due;
    st.out_busy = ov_r && !(out_tvalid && out_tready);
    st.any_sent = sent_r;
  end

  logic [2:0]  r_kind, r_status;
  logic [3:0]  r_num;
  logic [31:0] r_loc, r_rem, r_trans;
  logic [15:0] r_cnt;
  logic        r_up, r_chg, r_last;
  logic        wr_add;
  logic [IDX_W-1:0] wr_idx;

  always_comb begin
    r_kind = KIND_ADD; r_status = ST_OK; r_num = '0; r_loc = '0; r_rem = '0;
    r_cnt = '0; r_up = 1'b0; r_chg = 1'b0; r_trans = '0; r_last = 1'b1;
    wr_add = 1'b0;
    wr_idx = count_r[IDX_W-1:0];
    case (op_r)
      OP_ADD: begin
        r_kind = KIND_ADD;
        if (found_r) begin
          r_status = ST_DUP; r_num = 4'(fidx_r); r_loc = rd_loc; r_rem = rd_rem;
          r_cnt = rd_pend; r_up = rd_link; r_trans = rd_trans;
        end else if (full) begin
          r_status = ST_FULL; r_loc = loc_r; r_rem = rem_r;
        end else begin
          wr_add = 1'b1;
          r_num = 4'(count_r); r_loc = loc_r; r_rem = rem_r; r_up = link_init;
        end
      end
      OP_TICK: begin
        if (st.idx_end) begin
          r_kind = KIND_IDLE;
        end else begin
          r_kind = KIND_SENT; r_num = 4'(ptr_r); r_loc = rd_loc; r_rem = rd_rem;
          r_cnt = pend_tick; r_up = rd_link && !down_tick; r_chg = down_tick;
          r_trans = rd_trans + {31'd0, down_tick};
          // The final keepalive is known only once the rest of the walk is done.
          r_last = 1'b0;
        end
      end
      OP_ACK: begin
        r_kind = KIND_ACK;
        if (found_r) begin
          r_num = 4'(fidx_r); r_loc = rd_loc; r_rem = rd_rem; r_up = 1'b1;
          r_chg = !rd_link; r_trans = rd_trans + {31'd0, !rd_link};
        end else begin
          r_status = ST_NOTFOUND; r_loc = loc_r; r_rem = rem_r;
        end
      end
      default: begin
        r_kind = KIND_STAT; r_num = sidx_r;
        if (stat_ok) begin
          r_loc = rd_loc; r_rem = rd_rem; r_cnt = rd_pend; r_up = rd_link;
          r_trans = rd_trans;
        end else begin
          r_status = ST_BADIDX;
        end
      end
    endcase
  end

  // Table writes.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (op_r == OP_ADD && wr_add) begin
        m_loc[wr_idx] <= loc_r; m_rem[wr_idx] <= rem_r; m_per[wr_idx] <= per_r;
        m_rty[wr_idx] <= rty_r; m_pend[wr_idx] <= '0; m_nev[wr_idx] <= 1'b1;
        m_last[wr_idx] <= '0; m_link[wr_idx] <= link_init; m_trans[wr_idx] <= '0;
      end else if (op_r == OP_TICK && !st.idx_end) begin
        m_last[ptr_idx] <= secs_r; m_nev[ptr_idx] <= 1'b0;
        m_pend[ptr_idx] <= pend_tick; m_link[ptr_idx] <= r_up;
        m_trans[ptr_idx] <= r_trans;
      end else if (op_r == OP_ACK && found_r) begin
        m_pend[fidx_r] <= '0; m_nev[fidx_r] <= 1'b0; m_link[fidx_r] <= 1'b1;
        m_trans[fidx_r] <= r_trans;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0; secs_r <= '0; ptr_r <= '0; found_r <= 1'b0;
      op_r <= OP_ADD; sent_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        op_r <= in_tuser;
        found_r <= 1'b0;
        sent_r <= 1'b0;
        if (in_tuser == OP_TICK) secs_r <= secs_r + 32'd1;
      end
      if (cmd.clr_idx) ptr_r <= '0;
      else if (cmd.inc_idx) ptr_r <= ptr_r + CNT_W'(1);
      if (cmd.match_chk) begin
        if (hit) begin
          found_r <= 1'b1; fidx_r <= ptr_idx;
        end else begin
          ptr_r <= ptr_r + CNT_W'(1);
        end
      end
      if (cmd.commit && op_r == OP_ADD && wr_add) count_r <= count_r + CNT_W'(1);
      if (cmd.emit && op_r == OP_TICK) sent_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      loc_r <= in_tdata[31:0]; rem_r <= in_tdata[63:32];
      per_r <= in_tdata[79:64]; rty_r <= in_tdata[87:80];
      sidx_r <= in_tdata[91:88];
    end
  end

  // Output register. A keepalive stays hidden until the walk shows whether it
  // is the last one, so that tlast can be set on it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      hold_r <= 1'b0;
    end else if (cmd.emit) begin
      ov_r <= 1'b1;
      hold_r <= !r_last;
    end else begin
      if (out_tvalid && out_tready) ov_r <= 1'b0;
      if (cmd.rel) hold_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      od_r <= {7'd0, r_trans, r_chg, r_up, r_cnt, r_rem, r_loc, r_num, r_status};
      ou_r <= r_kind;
      olast_r <= r_last;
    end else if (cmd.fin) begin
      olast_r <= 1'b1;
    end
  end

  assign out_tvalid = ov_r && !hold_r;
  assign out_tdata = od_r;
  assign out_tuser = ou_r;
  assign out_tlast = olast_r;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast));
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_TUNNELS));
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !st.out_busy);
`endif

endmodule

@@ rtl/core/tunnel_keepalive_monitor_top.sv @@
// Keepalive monitor for up to 16 tunnels. Items are taken one at a time:
// add and ack search the table one entry at a time, statistics read the
// indexed entry directly, and a tick walks all N entries and sends a
// keepalive for each entry that is due.
// Each keepalive is held back until the next due entry or the end of the walk
// is found, so that the final one carries tlast; every result waits on
// out_tready.
module tunnel_keepalive_monitor_top
  import tkm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // local_addr, remote_addr, keepalive_period,
                                   // retry_limit, stat_index
  input  logic [1:0]   in_tuser,   // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // status, tunnel_number, peer_local,
                                   // peer_remote, unanswered_count, link_is_up,
                                   // link_changed, transition_total
  output logic [2:0]   out_tuser,  // result_kind
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [1:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  cmd_t  cmd;
  stat_t st;
  logic  link_init_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr == 2'(REG_INITIAL_LINK_UP * 4) ? {31'd0, link_init_r}
                                                               : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_init_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr == 2'(REG_INITIAL_LINK_UP * 4)) begin
      link_init_r <= cfg_pwdata[0];
    end
  end

  tkm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid && in_tready),
    .st(st), .cmd(cmd), .in_ready(in_tready)
  );

  tkm_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .in_tdata(in_tdata[91:0]), .in_tuser(in_tuser), .link_init(link_init_r),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

endmodule

@@ tb/sv/tb_tunnel_keepalive_monitor_top.sv @@
module tb_tunnel_keepalive_monitor_top;
  import tkm_pkg::*;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] loc;
    logic [31:0] rem;
    logic [15:0] period;
    logic [7:0]  retry;
    logic [3:0]  sidx;
    bit          drain_first;  // hold the item back until all results are in
  } req_t;

  typedef struct {
    logic [2:0]  kind;
    logic [2:0]  status;
    logic [3:0]  tnum;
    logic [31:0] loc;
    logic [31:0] rem;
    logic [15:0] cnt;
    logic        up;
    logic        chg;
    logic [31:0] trans;
    logic        last;
  } rsp_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [95:0]  in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [1:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  tunnel_keepalive_monitor_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #4 clk = ~clk;

  // Shadow copy of the tunnel table.
  int unsigned n_tunnels;
  logic [31:0] sh_loc [MAX_TUNNELS];
  logic [31:0] sh_rem [MAX_TUNNELS];
  logic [15:0] sh_period [MAX_TUNNELS];
  logic [7:0]  sh_retry [MAX_TUNNELS];
  logic [15:0] sh_pending [MAX_TUNNELS];
  logic        sh_fresh [MAX_TUNNELS];
  logic [31:0] sh_sent_at [MAX_TUNNELS];
  logic        sh_up [MAX_TUNNELS];
  logic [31:0] sh_trans [MAX_TUNNELS];
  logic [31:0] sh_seconds;
  logic        sh_init_up;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  req_t cur_req;
  int   errors;
  int   sender_idle_pct;
  int   stall_pct;
  int   unsigned cycle_count;

  // Generator view of the keys it has asked to add.
  logic [31:0] gen_loc[$];
  logic [31:0] gen_rem[$];

  function automatic rsp_t entry_rsp(logic [2:0] kind, logic [2:0] st, int i, logic chg);
    rsp_t r;
    r.kind = kind; r.status = st; r.tnum = i[3:0];
    r.loc = sh_loc[i]; r.rem = sh_rem[i]; r.cnt = sh_pending[i];
    r.up = sh_up[i]; r.chg = chg; r.trans = sh_trans[i]; r.last = 1'b0;
    return r;
  endfunction

  function automatic rsp_t raw_rsp(logic [2:0] kind, logic [2:0] st, logic [3:0] i,
                                   logic [31:0] l, logic [31:0] rm);
    rsp_t r;
    r.kind = kind; r.status = st; r.tnum = i; r.loc = l; r.rem = rm;
    r.cnt = '0; r.up = 1'b0; r.chg = 1'b0; r.trans = '0; r.last = 1'b0;
    return r;
  endfunction

  function automatic int lookup_tunnel(logic [31:0] l, logic [31:0] rm);
    for (int i = 0; i < n_tunnels; i++)
      if (sh_loc[i] == l && sh_rem[i] == rm) return i;
    return -1;
  endfunction

  task automatic predict_monitor(req_t q);
    rsp_t out[$];
    rsp_t r;
    int   f;
    logic chg;
    case (q.op)
      OP_ADD: begin
        f = lookup_tunnel(q.loc, q.rem);
        if (f >= 0) out.push_back(entry_rsp(KIND_ADD, ST_DUP, f, 1'b0));
        else if (n_tunnels >= MAX_TUNNELS)
          out.push_back(raw_rsp(KIND_ADD, ST_FULL, 4'd0, q.loc, q.rem));
        else begin
          f = int'(n_tunnels);
          n_tunnels++;
          sh_loc[f] = q.loc; sh_rem[f] = q.rem; sh_period[f] = q.period;
          sh_retry[f] = q.retry; sh_pending[f] = '0; sh_fresh[f] = 1'b1;
          sh_sent_at[f] = '0; sh_up[f] = sh_init_up; sh_trans[f] = '0;
          out.push_back(entry_rsp(KIND_ADD, ST_OK, f, 1'b0));
        end
      end
      OP_TICK: begin
        sh_seconds++;
        for (int i = 0; i < n_tunnels; i++) begin
          if (32'(sh_seconds - sh_sent_at[i]) >= {16'd0, sh_period[i]}) begin
            chg = 1'b0;
            sh_sent_at[i] = sh_seconds;
            if (sh_fresh[i]) begin
              sh_fresh[i] = 1'b0;
              sh_pending[i] = 16'd1;
            end else if (sh_pending[i] != 16'hFFFF) begin
              sh_pending[i]++;
            end
            if (sh_pending[i] > {8'd0, sh_retry[i]} && sh_up[i]) begin
              sh_up[i] = 1'b0;
              sh_trans[i]++;
              chg = 1'b1;
            end
            out.push_back(entry_rsp(KIND_SENT, ST_OK, i, chg));
          end
        end
        if (out.size() == 0) out.push_back(raw_rsp(KIND_IDLE, ST_OK, 4'd0, '0, '0));
      end
      OP_ACK: begin
        f = lookup_tunnel(q.loc, q.rem);
        if (f < 0) out.push_back(raw_rsp(KIND_ACK, ST_NOTFOUND, 4'd0, q.loc, q.rem));
        else begin
          chg = 1'b0;
          sh_pending[f] = '0;
          sh_fresh[f] = 1'b0;
          if (!sh_up[f]) begin
            sh_up[f] = 1'b1;
            sh_trans[f]++;
            chg = 1'b1;
          end
          out.push_back(entry_rsp(KIND_ACK, ST_OK, f, chg));
        end
      end
      default: begin
        if (q.sidx < n_tunnels)
          out.push_back(entry_rsp(KIND_STAT, ST_OK, int'(q.sidx), 1'b0));
        else out.push_back(raw_rsp(KIND_STAT, ST_BADIDX, q.sidx, '0, '0));
      end
    endcase
    out[out.size()-1].last = 1'b1;
    foreach (out[k]) expected_rsps.push_back(out[k]);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  // Input driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_monitor(cur_req);
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() == 0 || $urandom_range(99) < sender_idle_pct ||
            (pending_reqs[0].drain_first && expected_rsps.size() != 0)) begin
          in_tvalid <= 1'b0;
        end else begin
          cur_req = pending_reqs.pop_front();
          in_tdata <= {4'd0, cur_req.sidx, cur_req.retry, cur_req.period,
                       cur_req.rem, cur_req.loc};
          in_tuser <= cur_req.op;
          in_tvalid <= 1'b1;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    rsp_t w;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_rsps.size() == 0) begin
          $display("unexpected result item, kind %0d", out_tuser);
          errors++;
        end else begin
          w = expected_rsps.pop_front();
          if (out_tuser !== w.kind)
            report_mismatch("result_kind", 32'(out_tuser), 32'(w.kind));
          if (out_tdata[2:0] !== w.status)
            report_mismatch("status", 32'(out_tdata[2:0]), 32'(w.status));
          if (out_tdata[6:3] !== w.tnum)
            report_mismatch("tunnel_number", 32'(out_tdata[6:3]), 32'(w.tnum));
          if (out_tdata[38:7] !== w.loc) report_mismatch("peer_local", out_tdata[38:7], w.loc);
          if (out_tdata[70:39] !== w.rem)
            report_mismatch("peer_remote", out_tdata[70:39], w.rem);
          if (out_tdata[86:71] !== w.cnt)
            report_mismatch("unanswered_count", 32'(out_tdata[86:71]), 32'(w.cnt));
          if (out_tdata[87] !== w.up)
            report_mismatch("link_is_up", 32'(out_tdata[87]), 32'(w.up));
          if (out_tdata[88] !== w.chg)
            report_mismatch("link_changed", 32'(out_tdata[88]), 32'(w.chg));
          if (out_tdata[120:89] !== w.trans)
            report_mismatch("transition_total", out_tdata[120:89], w.trans);
          if (out_tlast !== w.last) report_mismatch("last", 32'(out_tlast), 32'(w.last));
        end
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 600000) begin
      $display("tunnel_keepalive_monitor_top verification failed");
      $finish;
    end
  end

  task automatic add_req(logic [1:0] op, logic [31:0] l, logic [31:0] rm, logic [15:0] per,
                         logic [7:0] rt, logic [3:0] si, bit drain);
    req_t q;
    q.op = op; q.loc = l; q.rem = rm; q.period = per; q.retry = rt; q.sidx = si;
    q.drain_first = drain;
    if (op == OP_ADD) begin
      gen_loc.push_back(l);
      gen_rem.push_back(rm);
    end
    pending_reqs.push_back(q);
  endtask

  task automatic add_random_reqs(int count);
    int          pick;
    int          k;
    logic [31:0] l;
    logic [31:0] rm;
    logic [15:0] per;
    logic [7:0]  rt;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      l = $urandom();
      rm = $urandom();
      if (gen_loc.size() != 0 && $urandom_range(99) < 75) begin
        k = $urandom_range(gen_loc.size() - 1);
        l = gen_loc[k];
        rm = gen_rem[k];
      end
      per = ($urandom_range(9) == 0) ? 16'($urandom_range(65535, 1))
                                     : 16'($urandom_range(5, 1));
      rt = ($urandom_range(9) == 0) ? 8'($urandom()) : 8'($urandom_range(3));
      if (pick < 18) add_req(OP_ADD, l, rm, per, rt, 4'($urandom()), 1'b0);
      else if (pick < 58) add_req(OP_TICK, $urandom(), $urandom(), 16'($urandom()),
                                  8'($urandom()), 4'($urandom()), 1'b0);
      else if (pick < 83) add_req(OP_ACK, l, rm, 16'($urandom()), 8'($urandom()),
                                  4'($urandom()), n == count / 2);
      else add_req(OP_STAT, $urandom(), $urandom(), 16'($urandom()), 8'($urandom()),
                   4'($urandom()), 1'b0);
    end
  endtask

  task automatic write_init_up(logic v);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= 2'(REG_INITIAL_LINK_UP * 4); cfg_pwdata <= {31'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    sh_init_up = v;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || expected_rsps.size() != 0)
      @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  initial begin
    n_tunnels = 0;
    sh_seconds = '0;
    sh_init_up = 1'b0;
    errors = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    stall_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, bad index, unknown ack, extreme keys and limits.
    add_req(OP_TICK, '0, '0, '0, '0, 4'd0, 1'b0);
    add_req(OP_STAT, '0, '0, '0, '0, 4'd0, 1'b0);
    add_req(OP_STAT, '1, '1, '1, '1, 4'd15, 1'b0);
    add_req(OP_ACK, 32'h0A000001, 32'h0A000002, '0, '0, 4'd0, 1'b0);
    add_req(OP_ADD, '0, '0, 16'd1, 8'd0, 4'd0, 1'b0);
    add_req(OP_ADD, '1, '1, 16'd65535, 8'd255, 4'd0, 1'b0);
    add_req(OP_ADD, '0, '0, 16'd3, 8'd9, 4'd0, 1'b0);
    add_req(OP_ADD, '1, '0, 16'd2, 8'd1, 4'd0, 1'b0);
    add_req(OP_TICK, '0, '0, '0, '0, 4'd0, 1'b1);
    add_req(OP_TICK, '0, '0, '0, '0, 4'd0, 1'b0);
    add_req(OP_TICK, '0, '0, '0, '0, 4'd0, 1'b0);
    add_req(OP_STAT, '0, '0, '0, '0, 4'd0, 1'b0);
    add_req(OP_ACK, '0, '0, '0, '0, 4'd0, 1'b0);
    add_req(OP_ACK, '1, '0, '0, '0, 4'd0, 1'b0);
    add_req(OP_ACK, '0, '1, '0, '0, 4'd0, 1'b0);
    add_req(OP_STAT, '0, '0, '0, '0, 4'd3, 1'b0);
    add_req(OP_STAT, '0, '0, '0, '0, 4'd4, 1'b0);
    add_req(OP_TICK, '0, '0, '0, '0, 4'd0, 1'b0);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      write_init_up(ph == 0 || ph == 2);
      sender_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 30 : 57) : 0;
      stall_pct = (ph == 2) ? 57 : ((ph == 3) ? 30 : 0);
      add_random_reqs(80);
      wait_drained();
    end

    // Keep ticking so that entries that fall due send keepalives.
    sender_idle_pct = 0;
    stall_pct = 0;
    for (int n = 0; n < 6; n++) add_req(OP_TICK, '0, '0, '0, '0, 4'd0, 1'b0);
    for (int i = 0; i < 16; i++) add_req(OP_STAT, '0, '0, '0, '0, 4'(i), 1'b0);
    wait_drained();

    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("tunnel_keepalive_monitor_top verification clean");
    end else begin
      $display("tunnel_keepalive_monitor_top verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/tkm_pkg.sv
rtl/core/tkm_ctrl.sv
rtl/core/tkm_datapath.sv
rtl/core/tunnel_keepalive_monitor_top.sv
tb/sv/tb_tunnel_keepalive_monitor_top.sv
